>>> rtl/core/tpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_pkg
// Types and constants for the period-measuring tachometer.
// ----------------------------------------------------------------------------
package tpr_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_PPR        = 3'd0;
    localparam logic [2:0] CFG_CORR_SHORT = 3'd1;
    localparam logic [2:0] CFG_CORR_LONG  = 3'd2;
    localparam logic [2:0] CFG_REC_EN     = 3'd3;
    localparam logic [2:0] CFG_REC_TORQUE = 3'd4;
    localparam logic [2:0] CFG_REC_LIMIT  = 3'd5;

    // Reset values of the configuration registers
    localparam logic [9:0]  PPR_RST  = 10'd1;
    localparam logic [15:0] CORR_RST = 16'd4096;

    // Recorder depth; record_limit and the sample count are 11 bits wide
    localparam logic [10:0] RECORD_DEPTH = 11'd1024;

    // Arithmetic constants
    localparam logic [31:0] PERIOD_MIN = 32'd5000;
    localparam logic [31:0] WRAP_BASE  = 32'h0000_ffff;
    localparam logic [7:0]  DIV_CONST  = 8'd100;
    localparam logic [25:0] RPM_NUM    = 26'd60_000_000;
    localparam logic [15:0] SAMPLE_MAX = 16'hffff;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_WDIV,
        ST_SUB,
        ST_M64,
        ST_M4,
        ST_ADDS,
        ST_SCALE,
        ST_PER,
        ST_DEN,
        ST_RPM,
        ST_SDIV,
        ST_DONE
    } t_state;

endpackage

>>> rtl/core/tachometer_period_to_rpm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tachometer_period_to_rpm
// Encoder period to signed rpm, with odometer and sample recorder.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_*       in         tuser {is_long, kind}; tdata {torque, direction, pulse_time}
//  m_*       out        tuser {record_done, sample_valid};
//                       tdata {sample_value, odometer, speed_rpm}
//  cfg_*     in         index 0..5, 16-bit write data, always ready
//
//  A torque beat passes only the start and done states. A pulse beat also
//  runs the bit-serial units it needs, and when the timestamp went backwards
//  it first runs a wrap correction. The units are the 16-step scaling multiplier,
//  the 10-step period by steps multiplier, the 26-step rpm divider and the 32-step
//  divider by 100. s_tready returns at the edge that loads the result.
//  A result waits in the output register while m_tready is low; the next
//  item is taken meanwhile and holds in its last step until the register frees.
//  Reset is synchronous and active low.
// ----------------------------------------------------------------------------
module tachometer_period_to_rpm
    import tpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // [31:0] pulse_time, [33:32] direction,
                                     // [49:34] torque, [55:50] zero
    input  logic [1:0]  i_s_tuser,   // [0] kind, [1] is_long
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [14:0] speed_rpm, [46:15] odometer,
                                     // [62:47] sample_value, [63] zero
    output logic [1:0]  o_m_tuser,   // [0] sample_valid, [1] record_done
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_state      r_state, n_state;
    logic [4:0]  r_cnt;
    logic [4:0]  w_cnt_load;

    // latched item
    logic        r_kind;
    logic        r_is_long;
    logic [31:0] r_stamp;
    logic [1:0]  r_dir;
    logic [15:0] r_torque;

    // configuration
    logic [9:0]  r_ppr;
    logic [15:0] r_corr_short;
    logic [15:0] r_corr_long;
    logic        r_rec_en;
    logic        r_rec_torque;
    logic [10:0] r_rec_limit;
    logic [10:0] w_limit_in;

    // block state
    logic [31:0] r_last_stamp;
    logic [31:0] r_odo;
    logic [14:0] r_last_speed;
    logic [10:0] r_rec_count;

    // datapath
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [47:0] r_mp;
    logic [41:0] r_dp;
    logic [25:0] r_q;
    logic [25:0] r_rem;
    logic [31:0] r_cd_num;
    logic [6:0]  r_cd_rem;

    logic [32:0] w_mp_sum;
    logic [32:0] w_dp_sum;
    logic [26:0] w_rt;
    logic        w_rge;
    logic [26:0] w_rdiff;
    logic [7:0]  w_ct;
    logic        w_cge;
    logic [7:0]  w_cdiff;
    logic [15:0] w_factor;
    logic [31:0] w_period;
    logic        w_rpm_ok;
    logic        w_can_rec;
    logic        w_take_per;
    logic        w_take_trq;
    logic        w_take;
    logic [15:0] w_sample;
    logic [15:0] w_sat_q;
    logic [14:0] w_rpm_mag;
    logic [14:0] w_speed;
    logic [14:0] w_speed_out;
    logic [31:0] w_odo;
    logic [10:0] w_count;
    logic        w_done_flag;

    // output register
    logic        r_m_valid;
    logic [63:0] r_m_data;
    logic [1:0]  r_m_user;

    // control
    logic        w_s_ready;
    logic        w_ld_out;
    logic        w_s_acc;

    assign w_s_acc     = i_s_tvalid && w_s_ready;
    assign o_s_tready  = w_s_ready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_m_tuser   = r_m_user;

    // ------------------------------------------------------------------
    // datapath combinational terms
    // ------------------------------------------------------------------
    assign w_factor = r_is_long ? r_corr_long : r_corr_short;
    assign w_mp_sum = {1'b0, r_mp[47:16]} + (r_mp[0] ? {1'b0, r_x} : 33'd0);
    assign w_period = (r_mp[47:44] != 4'd0) ? 32'hffff_ffff : r_mp[43:12];
    assign w_dp_sum = {1'b0, r_dp[41:10]} + (r_dp[0] ? {1'b0, w_period} : 33'd0);

    // restoring rpm divider; partial remainder never exceeds 26 bits
    assign w_rt    = {r_rem, r_q[25]};
    assign w_rge   = {15'd0, w_rt} >= r_dp;
    assign w_rdiff = w_rt - r_dp[26:0];

    // divide by 100, one quotient bit a cycle
    assign w_ct    = {r_cd_rem, r_cd_num[31]};
    assign w_cge   = w_ct >= DIV_CONST;
    assign w_cdiff = w_ct - DIV_CONST;

    assign w_rpm_ok  = (w_period > PERIOD_MIN) && (r_dir != 2'b00) && (r_ppr != 10'd0);
    assign w_can_rec = r_rec_en && (r_rec_count < r_rec_limit) &&
                       (r_rec_count < RECORD_DEPTH);
    assign w_take_per = !r_kind && !r_rec_torque && (w_period > PERIOD_MIN) && w_can_rec;
    assign w_take_trq = r_kind && r_rec_torque && w_can_rec;
    assign w_take     = w_take_per || w_take_trq;
    assign w_sat_q    = (r_cd_num[31:16] != 16'd0) ? SAMPLE_MAX : r_cd_num[15:0];

    always_comb begin
        priority if (w_take_trq) begin
            w_sample = r_torque;
        end else if (w_take_per) begin
            w_sample = w_sat_q;
        end else begin
            w_sample = 16'd0;
        end
    end

    assign w_rpm_mag = {1'b0, r_q[13:0]};
    assign w_speed   = !w_rpm_ok ? 15'd0 : (r_dir[1] ? 15'(-w_rpm_mag) : w_rpm_mag);
    assign w_speed_out = r_kind ? r_last_speed : w_speed;
    assign w_odo     = (!r_kind && r_dir == 2'b01) ? r_odo + 32'd1 : r_odo;
    assign w_count   = r_rec_count + {10'd0, w_take};
    assign w_done_flag = r_rec_en && (w_count >= r_rec_limit);

    assign w_limit_in = (i_cfg_data[10:0] > RECORD_DEPTH) ? RECORD_DEPTH : i_cfg_data[10:0];

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc) n_state = ST_START;
            end
            ST_START: begin
                priority if (r_kind) begin
                    n_state = ST_DONE;
                end else if (r_stamp < r_last_stamp) begin
                    n_state = ST_WDIV;
                end else begin
                    n_state = ST_SCALE;
                end
            end
            ST_WDIV: begin
                if (r_cnt == 5'd0) n_state = ST_SUB;
            end
            ST_SUB:   n_state = ST_M64;
            ST_M64:   n_state = ST_M4;
            ST_M4:    n_state = ST_ADDS;
            ST_ADDS:  n_state = ST_SCALE;
            ST_SCALE: begin
                if (r_cnt == 5'd0) n_state = ST_PER;
            end
            ST_PER: begin
                priority if (w_rpm_ok) begin
                    n_state = ST_DEN;
                end else if (w_take_per) begin
                    n_state = ST_SDIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DEN: begin
                if (r_cnt == 5'd0) n_state = ST_RPM;
            end
            ST_RPM: begin
                if (r_cnt == 5'd0) n_state = w_take_per ? ST_SDIV : ST_DONE;
            end
            ST_SDIV: begin
                if (r_cnt == 5'd0) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_m_valid || i_m_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        w_s_ready = 1'b0;
        w_ld_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: w_s_ready = 1'b1;
            ST_DONE: w_ld_out  = !r_m_valid || i_m_tready;
            default: begin
                w_s_ready = 1'b0;
                w_ld_out  = 1'b0;
            end
        endcase
    end

    // step count for the serial phases
    always_comb begin
        unique case (n_state)
            ST_WDIV:  w_cnt_load = 5'd31;
            ST_SCALE: w_cnt_load = 5'd15;
            ST_DEN:   w_cnt_load = 5'd9;
            ST_RPM:   w_cnt_load = 5'd25;
            ST_SDIV:  w_cnt_load = 5'd31;
            default:  w_cnt_load = 5'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            if (r_state != n_state) begin
                r_cnt <= w_cnt_load;
            end else if (r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // configuration and block state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr        <= PPR_RST;
            r_corr_short <= CORR_RST;
            r_corr_long  <= CORR_RST;
            r_rec_en     <= 1'b0;
            r_rec_torque <= 1'b0;
            r_rec_limit  <= 11'd0;
            r_last_stamp <= 32'd0;
            r_odo        <= 32'd0;
            r_last_speed <= 15'd0;
            r_rec_count  <= 11'd0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PPR:        r_ppr        <= i_cfg_data[9:0];
                    CFG_CORR_SHORT: r_corr_short <= i_cfg_data;
                    CFG_CORR_LONG:  r_corr_long  <= i_cfg_data;
                    CFG_REC_EN:     r_rec_en     <= i_cfg_data[0];
                    CFG_REC_TORQUE: r_rec_torque <= i_cfg_data[0];
                    CFG_REC_LIMIT:  r_rec_limit  <= w_limit_in;
                    default: ;
                endcase
            end
            // a write to the enable register restarts the sample count
            priority if (i_cfg_valid && i_cfg_index == CFG_REC_EN) begin
                r_rec_count <= 11'd0;
            end else if (w_ld_out) begin
                r_rec_count <= w_count;
            end else begin
                r_rec_count <= r_rec_count;
            end
            if (w_ld_out) begin
                r_odo        <= w_odo;
                r_last_speed <= w_speed_out;
                if (!r_kind) r_last_stamp <= r_stamp;
            end
        end
    end

    // ------------------------------------------------------------------
    // item latch and serial units
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_kind    <= i_s_tuser[0];
            r_is_long <= i_s_tuser[1];
            r_stamp   <= i_s_tdata[31:0];
            r_dir     <= i_s_tdata[33:32];
            r_torque  <= i_s_tdata[49:34];
        end

        // phase entry loads
        if (r_state != n_state) begin
            unique case (n_state)
                ST_WDIV: begin
                    r_cd_num <= r_last_stamp;
                    r_cd_rem <= 7'd0;
                end
                ST_SCALE: r_mp <= {32'd0, w_factor};
                ST_DEN:   r_dp <= {32'd0, r_ppr};
                ST_RPM: begin
                    r_q   <= RPM_NUM;
                    r_rem <= 26'd0;
                end
                ST_SDIV: begin
                    r_cd_num <= w_period;
                    r_cd_rem <= 7'd0;
                end
                default: ;
            endcase
        end

        // one step per cycle in each phase
        unique case (r_state)
            ST_START: r_x <= r_stamp - r_last_stamp;
            ST_WDIV, ST_SDIV: begin
                r_cd_rem <= w_cge ? w_cdiff[6:0] : w_ct[6:0];
                r_cd_num <= {r_cd_num[30:0], w_cge};
            end
            ST_SUB:   r_x <= WRAP_BASE - r_cd_num;
            // times 100 as 64 + 32 + 4, wrapping at 32 bits
            ST_M64:   r_y <= {r_x[25:0], 6'd0} + {r_x[26:0], 5'd0};
            ST_M4:    r_y <= r_y + {r_x[29:0], 2'd0};
            ST_ADDS:  r_x <= r_y + r_stamp;
            ST_SCALE: r_mp <= {w_mp_sum, r_mp[15:1]};
            ST_DEN:   r_dp <= {w_dp_sum, r_dp[9:1]};
            ST_RPM: begin
                r_rem <= w_rge ? w_rdiff[25:0] : w_rt[25:0];
                r_q   <= {r_q[24:0], w_rge};
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ld_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_m_data <= {1'b0, w_sample, w_odo, w_speed_out};
            r_m_user <= {w_done_flag, w_take};
        end
    end

endmodule

>>> rtl/core/tpr_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_chk
// Port-level checks for the tachometer, bound to the top level.
// ----------------------------------------------------------------------------
module tpr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [55:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [15:0] i_cfg_data
);

    // one item at a time: after an input beat the port closes
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in progress");

    // no sample recorded means a zero sample field
    a_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[62:47] == 16'd0))
        else $error("sample value without sample_valid");

    // speed stays within the reachable range
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[14:0]) <= 15'sd12000 &&
                        $signed(o_m_tdata[14:0]) >= -15'sd12000))
        else $error("speed out of range");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result beat changed under stall");

endmodule

bind tachometer_period_to_rpm tpr_chk u_tpr_chk (.*);
